FILE: sv/running_median_window_core_macros.svh
// Assertion macros shared by the running median window RTL.
// Expects clk and rst in scope at the point of use.
`ifndef RUNNING_MEDIAN_WINDOW_CORE_MACROS_SVH
`define RUNNING_MEDIAN_WINDOW_CORE_MACROS_SVH

// same-cycle implication
`define RMW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rmw_pkg.sv
// Shared types and constants for the running median window block.
// No dependencies; every other file but the macros header imports this package.
`default_nettype none

package rmw_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 5;
  localparam int INDEX_W   = 4;
  localparam int SUM_W     = 21;  // holds 31 full-scale samples with sign
  localparam int DEPTH_DEF = 16;
  localparam int MIN_WINDOW = 1;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WINDOW_SIZE = 1'b0
  } reg_idx_t;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [COUNT_W-1:0]         count_t;

  typedef struct packed {
    logic    start;
    logic    full;
    count_t  n_old;
    count_t  n_new;
    sample_t new_val;
    sample_t old_val;
  } sort_ctrl_t;

  typedef struct packed {
    sample_t median;
    sample_t lowest;
    sample_t highest;
  } sort_stats_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    count_t                  divisor;
  } div_req_t;

endpackage

`default_nettype wire

FILE: sv/rmw_if.sv
// Valid/ready channel interfaces for input items and result beats.
// Depends on rmw_pkg.
`default_nettype none

interface rmw_in_if;
  import rmw_pkg::*;
  logic                valid;
  logic                ready;
  logic                operation;
  sample_t             sample;
  logic [INDEX_W-1:0]  read_index;

  modport source (output valid, operation, sample, read_index, input ready);
  modport sink   (input valid, operation, sample, read_index, output ready);
endinterface

interface rmw_out_if;
  import rmw_pkg::*;
  logic    valid;
  logic    ready;
  sample_t median;
  sample_t average;
  sample_t lowest;
  sample_t highest;
  count_t  count;
  logic    has_data;
  sample_t indexed_value;
  logic    index_ok;

  modport source (output valid, median, average, lowest, highest, count, has_data,
                  indexed_value, index_ok, input ready);
  modport sink   (input valid, median, average, lowest, highest, count, has_data,
                  indexed_value, index_ok, output ready);
endinterface

`default_nettype wire

FILE: sv/rmw_divider.sv
// Restoring divider, one quotient bit per cycle: signed sum / unsigned count,
// truncating toward zero. Depends on rmw_pkg.
`default_nettype none

module rmw_divider (
  input  logic              clk,
  input  logic              rst,
  input  rmw_pkg::div_req_t req,
  output logic              busy,
  output rmw_pkg::sample_t  quotient
);
  import rmw_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]   mag;      // dividend bits shift out, quotient bits shift in
  logic [COUNT_W-1:0] rem;
  count_t             divisor;
  logic               neg;
  logic [STEP_W-1:0]  steps;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W:0]   rem_diff;
  logic               take;
  logic [SUM_W-1:0]   q_shift;
  logic [SUM_W-1:0]   abs_in;
  logic               launch;

  assign launch   = req.start && !busy;
  assign abs_in   = req.dividend[SUM_W-1] ? (SUM_W'(0) - SUM_W'(req.dividend))
                                          : SUM_W'(req.dividend);
  assign rem_sh   = {rem, mag[SUM_W-1]};
  assign take     = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign q_shift  = {mag[SUM_W-2:0], take};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (launch) begin
      busy  <= 1'b1;
      steps <= STEP_W'(SUM_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      mag     <= abs_in;
      rem     <= '0;
      divisor <= req.divisor;
      neg     <= req.dividend[SUM_W-1];
    end else if (busy) begin
      mag <= q_shift;
      rem <= take ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      if (steps == STEP_W'(1)) begin
        quotient <= neg ? SAMPLE_W'(SUM_W'(0) - q_shift) : SAMPLE_W'(q_shift);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/rmw_sorter.sv
// Keeps the window contents as a sorted list in a two-bank memory and
// rebuilds it per add by a one-pass merge (drop evicted, insert new).
// Depends on rmw_pkg.
`default_nettype none

module rmw_sorter #(
  parameter int DEPTH = rmw_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rmw_pkg::sort_ctrl_t  ctrl,
  output logic                 busy,
  output rmw_pkg::sort_stats_t stats
);
  import rmw_pkg::*;

  localparam int AW = $clog2(DEPTH);

  sample_t         mem [2][DEPTH];
  logic            cur;       // bank holding the current sorted list
  count_t          rd_k;
  count_t          wr_k;
  count_t          rd_k_inc;
  count_t          n_old;
  count_t          n_new;
  logic            removed;
  logic            inserted;
  sample_t         new_val;
  sample_t         old_val;
  sample_t         rdata;
  sample_t         wr_data;
  logic            launch;
  logic            have_e;
  logic            drop;
  logic            put_new;
  logic            put_old;
  logic            finish;
  logic            consume;
  logic            rd_en;
  logic            wr_en;
  logic [AW-1:0]   rd_addr;

  assign launch   = ctrl.start && !busy;
  assign have_e   = rd_k < n_old;
  assign rd_k_inc = rd_k + 1'b1;

  // one merge decision per cycle; rdata is the list entry at rd_k
  always_comb begin
    drop    = 1'b0;
    put_new = 1'b0;
    put_old = 1'b0;
    finish  = 1'b0;
    if (busy) begin
      priority if (have_e && !removed && rdata == old_val) drop = 1'b1;
      else if (!inserted && (!have_e || new_val <= rdata)) put_new = 1'b1;
      else if (have_e) put_old = 1'b1;
      else finish = 1'b1;
    end
  end

  assign consume = drop || put_old;
  assign wr_en   = put_new || put_old;
  assign wr_data = put_new ? new_val : rdata;
  assign rd_en   = launch ? (ctrl.n_old != '0) : (consume && rd_k_inc < n_old);
  assign rd_addr = launch ? '0 : AW'(rd_k_inc);

  always_ff @(posedge clk) begin
    if (wr_en) mem[!cur][AW'(wr_k)] <= wr_data;
    if (rd_en) rdata <= mem[cur][rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cur  <= 1'b0;
    end else if (launch) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
      cur  <= !cur;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      rd_k     <= '0;
      wr_k     <= '0;
      removed  <= !ctrl.full;
      inserted <= 1'b0;
      n_old    <= ctrl.n_old;
      n_new    <= ctrl.n_new;
      new_val  <= ctrl.new_val;
      old_val  <= ctrl.old_val;
    end else begin
      if (consume) rd_k <= rd_k_inc;
      if (drop) removed <= 1'b1;
      if (put_new) inserted <= 1'b1;
      if (wr_en) begin
        wr_k <= wr_k + 1'b1;
        // pick rank statistics off the write stream
        if (wr_k == '0) stats.lowest <= wr_data;
        if (wr_k == (n_new >> 1)) stats.median <= wr_data;
        if (wr_k == n_new - 1'b1) stats.highest <= wr_data;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/running_median_window_core.sv
// Running median window: circular window of signed 16-bit samples with an
// APB size register and valid/ready item and result channels. A clear item
// goes straight to the done state; an add item passes the old, start and
// wait states, waiting on the bit-serial divider that forms the mean and on
// the parallel sorted-list merge for median, lowest and highest. The done
// state loads the output register once it is free. Input is not ready
// while an item is in work; a finished beat may sit in the output register
// while the next item is accepted. Writing window_size restarts the window.
// Depends on rmw_pkg, rmw_if, rmw_divider, rmw_sorter and the macros header.
`default_nettype none
`include "running_median_window_core_macros.svh"

module running_median_window_core #(
  parameter int DEPTH = rmw_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmw_pkg::PADDR_W-1:0] paddr,
  input  logic [rmw_pkg::PDATA_W-1:0] pwdata,
  output logic [rmw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  rmw_in_if.sink                      item,
  rmw_out_if.source                   result
);
  import rmw_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
  localparam count_t MIN_SIZE = count_t'(MIN_WINDOW);
  localparam count_t MAX_SIZE = count_t'((DEPTH < 31) ? DEPTH : 31);
  localparam count_t SIZE_RST = count_t'((DEPTH < 16) ? DEPTH : 16);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_OLD   = 5'b00010,
    S_START = 5'b00100,
    S_WAIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                  state;
  count_t                  size;
  count_t                  size_wr;
  logic [AW-1:0]           pos;
  logic [AW:0]             pos_inc;
  logic                    pos_wrap;
  count_t                  count;
  count_t                  count_next;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  op_t                     op_r;
  sample_t                 sample_r;
  logic [INDEX_W-1:0]      ridx_r;
  sample_t                 store [DEPTH];
  sample_t                 store_rdata;
  logic                    store_rd;
  logic [AW-1:0]           store_addr;
  logic                    full;
  logic                    accept;
  logic                    cfg_sel;
  logic                    cfg_wr;
  logic                    has;
  logic                    ok;
  logic                    out_load;
  sort_ctrl_t              sort_ctrl;
  sort_stats_t             sort_stats;
  logic                    sort_busy;
  div_req_t                div_req;
  logic                    div_busy;
  sample_t                 div_q;

  // config port
  assign pready  = 1'b1;
  assign cfg_sel = reg_idx_t'(paddr[PADDR_W-1:2]) == REG_WINDOW_SIZE;
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? PDATA_W'(size) : '0;

  always_comb begin
    size_wr = pwdata[COUNT_W-1:0];
    if (size_wr < MIN_SIZE) size_wr = MIN_SIZE;
    if (size_wr > MAX_SIZE) size_wr = MAX_SIZE;
  end

  assign item.ready = (state == S_IDLE) && !rst;
  assign accept     = item.valid && item.ready;

  // window bookkeeping for an add
  assign full       = (count == size);
  assign pos_inc    = {1'b0, pos} + 1'b1;
  assign pos_wrap   = PW'(pos_inc) >= PW'(size);
  assign count_next = (count < size) ? count + 1'b1 : count;
  assign sum_next   = sum + SUM_W'(sample_r) - (full ? SUM_W'(store_rdata) : SUM_W'(0));

  // store: evicted entry read on accept, indexed entry read after the write
  assign store_rd   = accept || (state == S_START);
  assign store_addr = (state == S_IDLE) ? pos : AW'(ridx_r);

  always_ff @(posedge clk) begin
    if (state == S_OLD) store[pos] <= sample_r;
    if (store_rd) store_rdata <= store[store_addr];
  end

  assign sort_ctrl.start   = (state == S_OLD);
  assign sort_ctrl.full    = full;
  assign sort_ctrl.n_old   = count;
  assign sort_ctrl.n_new   = count_next;
  assign sort_ctrl.new_val = sample_r;
  assign sort_ctrl.old_val = store_rdata;

  assign div_req.start    = (state == S_START);
  assign div_req.dividend = sum;
  assign div_req.divisor  = count;

  rmw_sorter #(.DEPTH(DEPTH)) u_sorter (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (sort_ctrl),
    .busy  (sort_busy),
    .stats (sort_stats)
  );

  rmw_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      size  <= SIZE_RST;
      pos   <= '0;
      count <= '0;
      sum   <= '0;
    end else if (cfg_wr) begin
      size  <= size_wr;
      pos   <= '0;
      count <= '0;
      sum   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op_t'(item.operation) == OP_CLEAR) begin
              pos   <= '0;
              count <= '0;
              sum   <= '0;
              state <= S_DONE;
            end else begin
              state <= S_OLD;
            end
          end
        end
        S_OLD: begin
          pos   <= pos_wrap ? '0 : pos_inc[AW-1:0];
          count <= count_next;
          sum   <= sum_next;
          state <= S_START;
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (!sort_busy && !div_busy) state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(item.operation);
      sample_r <= item.sample;
      ridx_r   <= item.read_index;
    end
  end

  // output register
  assign has      = (count != '0);
  assign ok       = has && (COUNT_W'(ridx_r) < count);
  assign out_load = (state == S_DONE) && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.median        <= has ? sort_stats.median : '0;
      result.lowest        <= has ? sort_stats.lowest : '0;
      result.highest       <= has ? sort_stats.highest : '0;
      result.average       <= (has && op_r == OP_ADD) ? div_q : '0;
      result.count         <= count;
      result.has_data      <= has;
      result.indexed_value <= ok ? store_rdata : '0;
      result.index_ok      <= ok;
    end
  end

  `RMW_ASSERT_IMP(a_count_in_window, 1'b1, count <= size, "fill count above window size")
  `RMW_ASSERT_IMP(a_pos_in_window, 1'b1, PW'(pos) < PW'(size), "write position past window")
  `RMW_ASSERT_IMP(a_units_idle_on_accept, accept, !sort_busy && !div_busy, "item taken while busy")
  `RMW_ASSERT_NXT(a_merge_launched, state == S_OLD, sort_busy, "merge did not start")

endmodule

`default_nettype wire
